### sv/imacc_pkg.sv
// ----------------------------------------------------------------------------
// Integer tile matmul accumulator package
// Tile geometry, field widths, command and register codes, and the
// saturating byte-pair product shared by the accumulator datapath.
// ----------------------------------------------------------------------------
package imacc_pkg;

  // Tile geometry.
  localparam int TILE_ROWS      = 6;
  localparam int TILE_COLS      = 32;
  localparam int LANES_PER_ITEM = 4;
  localparam int NUM_GROUPS     = (TILE_COLS + LANES_PER_ITEM - 1) / LANES_PER_ITEM;

  // Field widths fixed by the interface.
  localparam int DATA_W  = 16;
  localparam int ROW_W   = 3;
  localparam int GROUP_W = 3;
  localparam int PACK_W  = 64;
  localparam int A_ROWS  = 6;

  // Last row and group of a tile, for the end-of-tile flag.
  localparam logic [ROW_W-1:0]   LAST_ROW   = ROW_W'(TILE_ROWS - 1);
  localparam logic [GROUP_W-1:0] LAST_GROUP = GROUP_W'(NUM_GROUPS - 1);

  // Command codes.
  localparam logic CMD_ACCUM = 1'b0;
  localparam logic CMD_EMIT  = 1'b1;

  // Configuration register indexes.
  localparam logic CFG_ALPHA = 1'b0;
  localparam logic CFG_BETA  = 1'b1;

  // Register reset values.
  localparam logic [DATA_W-1:0] ALPHA_RESET = 16'd1;
  localparam logic [DATA_W-1:0] BETA_RESET  = 16'd0;

  typedef logic [DATA_W-1:0] word_t;

  // Unsigned A pair times signed B pair, both k terms summed, then saturated
  // to the signed 16-bit range.
  function automatic word_t pair_product(input logic [15:0] a_pair,
                                         input logic [15:0] b_pair);
    logic signed [17:0] a_lo;
    logic signed [17:0] a_hi;
    logic signed [17:0] b_lo;
    logic signed [17:0] b_hi;
    logic signed [17:0] sum;
    word_t              res;
    a_lo = $signed({10'd0, a_pair[7:0]});
    a_hi = $signed({10'd0, a_pair[15:8]});
    b_lo = $signed({{10{b_pair[7]}}, b_pair[7:0]});
    b_hi = $signed({{10{b_pair[15]}}, b_pair[15:8]});
    sum  = a_lo * b_lo + a_hi * b_hi;
    if (sum > 18'sd32767) begin
      res = 16'h7FFF;
    end else if (sum < -18'sd32768) begin
      res = 16'h8000;
    end else begin
      res = sum[15:0];
    end
    return res;
  endfunction

endpackage

### sv/int8_tile_matmul_accumulator_unit.sv
// ----------------------------------------------------------------------------
// Integer tile matmul accumulator unit
// An emit transfer is registered in the input register, then in the result register,
// which raises the result strobe together with the row, group and c_new.
// Throughput: one transfer per cycle; busy stays low and results are never held.
// Each item is one read-modify-write of a column group of the accumulator tile.
// Reset clears all accumulators at once and loads alpha 1, beta 0.
// ----------------------------------------------------------------------------
module int8_tile_matmul_accumulator_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Command channel.
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic                            cmd_i,
  input  logic [imacc_pkg::ROW_W-1:0]     row_index_i,
  input  logic [imacc_pkg::GROUP_W-1:0]   column_group_i,
  input  logic [15:0]                     a_pair_row0_i,
  input  logic [15:0]                     a_pair_row1_i,
  input  logic [15:0]                     a_pair_row2_i,
  input  logic [15:0]                     a_pair_row3_i,
  input  logic [15:0]                     a_pair_row4_i,
  input  logic [15:0]                     a_pair_row5_i,
  input  logic [imacc_pkg::PACK_W-1:0]    b_pairs_i,
  input  logic [imacc_pkg::PACK_W-1:0]    c_old_i,
  // Configuration write port.
  input  logic                            cfg_we_i,
  input  logic                            cfg_index_i,
  input  logic [imacc_pkg::DATA_W-1:0]    cfg_data_i,
  // Result channel.
  output logic                            out_strobe_o,
  output logic [imacc_pkg::ROW_W-1:0]     out_row_o,
  output logic [imacc_pkg::GROUP_W-1:0]   out_group_o,
  output logic [imacc_pkg::PACK_W-1:0]    c_new_o,
  output logic                            last_o
);
  import imacc_pkg::*;

  // One column group of the tile: every row and lane of that group.
  typedef logic [TILE_ROWS-1:0][LANES_PER_ITEM-1:0][DATA_W-1:0] acc_group_t;

  // Configuration registers.
  word_t alpha_q;
  word_t beta_q;

  // Input register.
  logic                 item_vld_q;
  logic                 cmd_q;
  logic [ROW_W-1:0]     row_q;
  logic [GROUP_W-1:0]   grp_q;
  logic [15:0]          a_q [A_ROWS];
  logic [PACK_W-1:0]    b_q;
  logic [PACK_W-1:0]    c_q;

  // Accumulator tile, one entry per column group.
  acc_group_t acc_q [NUM_GROUPS];

  // Datapath values.
  word_t                prod     [TILE_ROWS][LANES_PER_ITEM];
  acc_group_t           grp_rd;
  acc_group_t           grp_wr;
  word_t                acc_rd   [LANES_PER_ITEM];
  logic [2*DATA_W-1:0]  alpha_mul[LANES_PER_ITEM];
  logic [2*DATA_W-1:0]  beta_mul [LANES_PER_ITEM];
  logic [PACK_W-1:0]    c_new_d;
  logic                 row_in_tile;

  // Result register.
  logic                 out_strobe_q;
  logic [ROW_W-1:0]     out_row_q;
  logic [GROUP_W-1:0]   out_group_q;
  logic [PACK_W-1:0]    c_new_q;
  logic                 last_q;

  // The datapath takes a transfer in every cycle, so busy never rises.
  assign busy_o = 1'b0;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= ALPHA_RESET;
      beta_q  <= BETA_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_ALPHA: alpha_q <= cfg_data_i;
        CFG_BETA:  beta_q  <= cfg_data_i;
        default:   ;
      endcase
    end
  end

  // Input register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
    end else begin
      item_vld_q <= start_i && !busy_o;
    end
  end

  // Input register payload, loaded on each accepted transfer.
  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      cmd_q  <= cmd_i;
      row_q  <= row_index_i;
      grp_q  <= column_group_i;
      a_q[0] <= a_pair_row0_i;
      a_q[1] <= a_pair_row1_i;
      a_q[2] <= a_pair_row2_i;
      a_q[3] <= a_pair_row3_i;
      a_q[4] <= a_pair_row4_i;
      a_q[5] <= a_pair_row5_i;
      b_q    <= b_pairs_i;
      c_q    <= c_old_i;
    end
  end

  // Saturated pair products for every row and lane of the group.
  always_comb begin
    for (int r = 0; r < TILE_ROWS; r++) begin
      for (int l = 0; l < LANES_PER_ITEM; l++) begin
        prod[r][l] = pair_product(a_q[r], b_q[16*l +: 16]);
      end
    end
  end

  assign row_in_tile = (row_q < TILE_ROWS);

  // Next value of the addressed group: add the products on accumulate, clear
  // the emitted row on emit when that row lies in the tile.
  always_comb begin
    grp_rd = acc_q[grp_q];
    grp_wr = grp_rd;
    if (cmd_q == CMD_ACCUM) begin
      for (int r = 0; r < TILE_ROWS; r++) begin
        for (int l = 0; l < LANES_PER_ITEM; l++) begin
          grp_wr[r][l] = grp_rd[r][l] + prod[r][l];
        end
      end
    end else if (row_in_tile) begin
      grp_wr[row_q] = '0;
    end
  end

  // Emit path: scale the accumulators and the old C values, then add.
  always_comb begin
    c_new_d = '0;
    for (int l = 0; l < LANES_PER_ITEM; l++) begin
      acc_rd[l]    = row_in_tile ? grp_rd[row_q][l] : '0;
      alpha_mul[l] = alpha_q * acc_rd[l];
      beta_mul[l]  = beta_q * c_q[16*l +: 16];
      c_new_d[16*l +: 16] = alpha_mul[l][DATA_W-1:0] + beta_mul[l][DATA_W-1:0];
    end
  end

  // Accumulator write-back, one column group per item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
        acc_q[g] <= '0;
      end
    end else if (item_vld_q) begin
      acc_q[grp_q] <= grp_wr;
    end
  end

  // Result strobe, one cycle per emit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_strobe_q <= 1'b0;
    end else begin
      out_strobe_q <= item_vld_q && (cmd_q == CMD_EMIT);
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (item_vld_q && (cmd_q == CMD_EMIT)) begin
      out_row_q   <= row_q;
      out_group_q <= grp_q;
      c_new_q     <= c_new_d;
      last_q      <= (row_q == LAST_ROW) && (grp_q == LAST_GROUP);
    end
  end

  assign out_strobe_o = out_strobe_q;
  assign out_row_o    = out_row_q;
  assign out_group_o  = out_group_q;
  assign c_new_o      = c_new_q;
  assign last_o       = last_q;

endmodule

### tb/sv/tb_int8_tile_matmul_accumulator_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Integer tile matmul accumulator unit testbench
// Drives accumulate and emit commands and keeps a shadow copy of the 6x32
// accumulator tile and of the scale registers. Every emitted row group is
// compared field by field against it or a typed c_new. Directed commands from a
// short table come first. Then, for each of several scale settings, random
// commands run, followed by full tile sweeps with random operands.
// ----------------------------------------------------------------------------
module tb_int8_tile_matmul_accumulator_unit;
  import imacc_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int SETTLE_WAIT  = 4;
  localparam int K_PAIRS      = 2;
  localparam int RANDOM_ITEMS = 40;
  localparam int NUM_PHASES   = 4;
  localparam int DIR_ROWS     = 17;

  localparam logic [A_ROWS-1:0][15:0] A_ZERO    = '0;
  localparam logic [A_ROWS-1:0][15:0] A_ONES    = {A_ROWS{16'hFFFF}};
  localparam logic [A_ROWS-1:0][15:0] A_ROW1    = {64'h0, 16'hFFFF, 16'h0};
  localparam logic [A_ROWS-1:0][15:0] A_LO_ONE  = {A_ROWS{16'hFF01}};
  localparam logic [A_ROWS-1:0][15:0] A_MIXED   =
    {16'h1234, 16'h80FF, 16'h7F00, 16'h00FF, 16'hFFFF, 16'hA55A};
  localparam logic [PACK_W-1:0]       B_EXTREME = 64'h0001_0000_8080_7F7F;
  localparam logic [PACK_W-1:0]       C_ONES    = '1;

  // One command as it sits on the input ports.
  typedef struct packed {
    logic                     cmd;
    logic [ROW_W-1:0]         row;
    logic [GROUP_W-1:0]       grp;
    logic [A_ROWS-1:0][15:0]  a;
    logic [PACK_W-1:0]        b;
    logic [PACK_W-1:0]        c;
  } tile_cmd_t;

  // Directed row: the command and, where obvious, the c_new it must give.
  typedef struct packed {
    tile_cmd_t          op;
    logic               typed;
    logic [PACK_W-1:0]  c_typed;
  } directed_row_t;

  typedef struct packed {
    logic [ROW_W-1:0]   row;
    logic [GROUP_W-1:0] grp;
    logic [PACK_W-1:0]  c_new;
    logic               last;
  } emit_result_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start_i;
  logic                 busy_o;
  logic                 cmd_i;
  logic [ROW_W-1:0]     row_index_i;
  logic [GROUP_W-1:0]   column_group_i;
  logic [15:0]          a_pair_row0_i;
  logic [15:0]          a_pair_row1_i;
  logic [15:0]          a_pair_row2_i;
  logic [15:0]          a_pair_row3_i;
  logic [15:0]          a_pair_row4_i;
  logic [15:0]          a_pair_row5_i;
  logic [PACK_W-1:0]    b_pairs_i;
  logic [PACK_W-1:0]    c_old_i;
  logic                 cfg_we_i;
  logic                 cfg_index_i;
  logic [DATA_W-1:0]    cfg_data_i;
  logic                 out_strobe_o;
  logic [ROW_W-1:0]     out_row_o;
  logic [GROUP_W-1:0]   out_group_o;
  logic [PACK_W-1:0]    c_new_o;
  logic                 last_o;

  // Driven command and the typed-in expectation that travels with it.
  tile_cmd_t            drv_cmd;
  logic                 drv_typed;
  logic [PACK_W-1:0]    drv_c_typed;

  // Shadow tile, scale registers and the emits still owed by the block.
  word_t                tile_acc [TILE_ROWS*TILE_COLS];
  word_t                alpha_q;
  word_t                beta_q;
  emit_result_t         owed_emits [$];

  int                   fail_count;
  int                   emit_count;
  int                   accum_count;
  int                   cycle_count;
  directed_row_t        dir_tab [DIR_ROWS];

  assign cmd_i          = drv_cmd.cmd;
  assign row_index_i    = drv_cmd.row;
  assign column_group_i = drv_cmd.grp;
  assign a_pair_row0_i  = drv_cmd.a[0];
  assign a_pair_row1_i  = drv_cmd.a[1];
  assign a_pair_row2_i  = drv_cmd.a[2];
  assign a_pair_row3_i  = drv_cmd.a[3];
  assign a_pair_row4_i  = drv_cmd.a[4];
  assign a_pair_row5_i  = drv_cmd.a[5];
  assign b_pairs_i      = drv_cmd.b;
  assign c_old_i        = drv_cmd.c;

  int8_tile_matmul_accumulator_unit DUT (.*);

  // Clock: 10 ns period.
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Unsigned A bytes times signed B bytes over one k pair, saturated to 16 bits.
  function automatic word_t sat_pair_dot(input logic [15:0] a_pair,
                                         input logic [15:0] b_pair);
    int a_lo;
    int a_hi;
    int b_lo;
    int b_hi;
    int dot;
    a_lo = a_pair[7:0];
    a_hi = a_pair[15:8];
    b_lo = $signed(b_pair[7:0]);
    b_hi = $signed(b_pair[15:8]);
    dot  = a_lo * b_lo + a_hi * b_hi;
    if (dot > 32767) begin
      dot = 32767;
    end else if (dot < -32768) begin
      dot = -32768;
    end
    return word_t'(dot);
  endfunction

  // Applies one accepted command to the shadow tile; an emit queues its result.
  task automatic update_tile(input tile_cmd_t t, input logic typed,
                             input logic [PACK_W-1:0] c_typed);
    emit_result_t res;
    int           col;
    int           idx;
    word_t        acc;
    word_t        c_lane;
    if (t.cmd == CMD_ACCUM) begin
      accum_count++;
      for (int r = 0; r < TILE_ROWS && r < A_ROWS; r++) begin
        for (int l = 0; l < LANES_PER_ITEM; l++) begin
          col = t.grp * LANES_PER_ITEM + l;
          if (col < TILE_COLS) begin
            idx = r * TILE_COLS + col;
            tile_acc[idx] = tile_acc[idx] + sat_pair_dot(t.a[r], t.b[16*l +: 16]);
          end
        end
      end
    end else begin
      res.row   = t.row;
      res.grp   = t.grp;
      res.c_new = '0;
      for (int l = 0; l < LANES_PER_ITEM; l++) begin
        col    = t.grp * LANES_PER_ITEM + l;
        acc    = '0;
        c_lane = t.c[16*l +: 16];
        // Entries outside the tile read as zero and are left alone.
        if (t.row < TILE_ROWS && col < TILE_COLS) begin
          idx           = t.row * TILE_COLS + col;
          acc           = tile_acc[idx];
          tile_acc[idx] = '0;
        end
        res.c_new[16*l +: 16] = word_t'(alpha_q * acc) + word_t'(beta_q * c_lane);
      end
      res.last = (t.row == LAST_ROW) && (t.grp == LAST_GROUP);
      if (typed) begin
        res.c_new = c_typed;
      end
      owed_emits.push_back(res);
    end
  endtask

  // Compares one strobed result with the oldest owed emit.
  task automatic check_emit();
    emit_result_t exp;
    if (owed_emits.size() == 0) begin
      $error("result with no emit owed: row %0d group %0d c_new %h",
             out_row_o, out_group_o, c_new_o);
      fail_count++;
    end else begin
      exp = owed_emits.pop_front();
      emit_count++;
      if (out_row_o !== exp.row) begin
        $error("out_row: expected %0d, actual %0d", exp.row, out_row_o);
        fail_count++;
      end
      if (out_group_o !== exp.grp) begin
        $error("out_group: expected %0d, actual %0d", exp.grp, out_group_o);
        fail_count++;
      end
      if (c_new_o !== exp.c_new) begin
        $error("c_new: expected %h, actual %h", exp.c_new, c_new_o);
        fail_count++;
      end
      if (last_o !== exp.last) begin
        $error("last: expected %0b, actual %0b", exp.last, last_o);
        fail_count++;
      end
    end
  endtask

  // Monitor: results first, then register writes, then the command transfer.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_strobe_o) begin
        check_emit();
      end
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_ALPHA) begin
          alpha_q = cfg_data_i;
        end else begin
          beta_q = cfg_data_i;
        end
      end
      if (start_i && !busy_o) begin
        update_tile(drv_cmd, drv_typed, drv_c_typed);
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Presents one command, possibly after a random gap, and waits for its transfer.
  task automatic send_cmd(input tile_cmd_t t, input logic typed,
                          input logic [PACK_W-1:0] c_typed, input int idle_pct);
    @(negedge clk_i);
    if ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    drv_cmd     <= t;
    drv_typed   <= typed;
    drv_c_typed <= c_typed;
    start_i     <= 1'b1;
    do @(posedge clk_i); while (busy_o !== 1'b0);
  endtask

  // Holds the sender off until every owed emit has come back and the block settles.
  task automatic wait_emits_drained();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (owed_emits.size() != 0) @(posedge clk_i);
    repeat (SETTLE_WAIT) @(posedge clk_i);
  endtask

  task automatic write_scale(input logic idx, input word_t value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Random operands; a quarter of the A rows are kept small to avoid saturation.
  task automatic randomize_operands(inout tile_cmd_t t);
    for (int r = 0; r < A_ROWS; r++) begin
      t.a[r] = 16'($urandom);
      if ($urandom_range(3) == 0) begin
        t.a[r] = t.a[r] & 16'h0F0F;
      end
    end
    t.b = {$urandom, $urandom};
    t.c = {$urandom, $urandom};
  endtask

  // Unordered mix of accumulates and emits, rows past the tile included.
  task automatic run_random_mix(input int n, input int idle_pct);
    tile_cmd_t t;
    repeat (n) begin
      randomize_operands(t);
      t.cmd = ($urandom_range(99) < 35) ? CMD_EMIT : CMD_ACCUM;
      t.row = ROW_W'($urandom_range(7));
      t.grp = GROUP_W'($urandom_range(7));
      send_cmd(t, 1'b0, '0, idle_pct);
    end
  endtask

  // A whole tile: k pairs into every column group, then every row group emitted.
  task automatic run_tile_sweep(input int idle_pct);
    tile_cmd_t t;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      for (int k = 0; k < K_PAIRS; k++) begin
        randomize_operands(t);
        t.cmd = CMD_ACCUM;
        t.row = ROW_W'($urandom_range(7));
        t.grp = GROUP_W'(g);
        // Odd final k: the high B bytes carry zero.
        if (k == K_PAIRS - 1 && $urandom_range(1) == 1) begin
          t.b = t.b & 64'h00FF_00FF_00FF_00FF;
        end
        send_cmd(t, 1'b0, '0, idle_pct);
      end
    end
    for (int r = 0; r < TILE_ROWS; r++) begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
        randomize_operands(t);
        t.cmd = CMD_EMIT;
        t.row = ROW_W'(r);
        t.grp = GROUP_W'(g);
        send_cmd(t, 1'b0, '0, idle_pct);
      end
    end
  endtask

  initial begin
    int    phase_idle [NUM_PHASES] = '{0, 56, 0, 33};
    word_t phase_alpha [NUM_PHASES];
    word_t phase_beta [NUM_PHASES];

    rst_ni      = 1'b0;
    start_i     = 1'b0;
    drv_cmd     = '0;
    drv_typed   = 1'b0;
    drv_c_typed = '0;
    cfg_we_i    = 1'b0;
    cfg_index_i = CFG_ALPHA;
    cfg_data_i  = '0;
    fail_count  = 0;
    emit_count  = 0;
    accum_count = 0;
    cycle_count = 0;
    alpha_q     = ALPHA_RESET;
    beta_q      = BETA_RESET;
    foreach (tile_acc[i]) tile_acc[i] = '0;

    // Scale settings per phase: both extremes, a plain pass-through, then random.
    phase_alpha = '{16'h8000, 16'h7FFF, 16'h0000, word_t'($urandom)};
    phase_beta  = '{16'h7FFF, 16'h8000, 16'h0001, word_t'($urandom)};

    // Directed commands under the reset scales (alpha one, beta zero).
    dir_tab[0]  = '{'{CMD_EMIT, 3'd0, 3'd0, A_ZERO, 64'h0, C_ONES}, 1'b1, 64'h0};
    dir_tab[1]  = '{'{CMD_ACCUM, 3'd7, 3'd0, A_ONES, B_EXTREME, C_ONES}, 1'b0, 64'h0};
    dir_tab[2]  = '{'{CMD_EMIT, 3'd0, 3'd0, A_ZERO, 64'h0, 64'h0},
                    1'b1, 64'h00FF_0000_8000_7FFF};
    dir_tab[3]  = '{'{CMD_EMIT, 3'd0, 3'd0, A_ZERO, 64'h0, 64'h0}, 1'b1, 64'h0};
    dir_tab[4]  = '{'{CMD_ACCUM, 3'd0, 3'd7, A_ONES, B_EXTREME, 64'h0}, 1'b0, 64'h0};
    dir_tab[5]  = '{'{CMD_EMIT, 3'd5, 3'd7, A_ZERO, 64'h0, C_ONES},
                    1'b1, 64'h00FF_0000_8000_7FFF};
    dir_tab[6]  = '{'{CMD_EMIT, 3'd6, 3'd3, A_ZERO, 64'h0, C_ONES}, 1'b1, 64'h0};
    dir_tab[7]  = '{'{CMD_EMIT, 3'd7, 3'd0, A_ZERO, 64'h0, 64'h8000_7FFF_1234_5678},
                    1'b1, 64'h0};
    // Three saturated sums into one entry wrap past the signed range.
    dir_tab[8]  = '{'{CMD_ACCUM, 3'd1, 3'd2, A_ROW1, 64'h7F7F, 64'h0}, 1'b0, 64'h0};
    dir_tab[9]  = '{'{CMD_ACCUM, 3'd1, 3'd2, A_ROW1, 64'h7F7F, 64'h0}, 1'b0, 64'h0};
    dir_tab[10] = '{'{CMD_ACCUM, 3'd1, 3'd2, A_ROW1, 64'h7F7F, 64'h0}, 1'b0, 64'h0};
    dir_tab[11] = '{'{CMD_EMIT, 3'd1, 3'd2, A_ZERO, 64'h0, 64'h0}, 1'b1, 64'h7FFD};
    dir_tab[12] = '{'{CMD_ACCUM, 3'd0, 3'd1, A_ZERO, C_ONES, 64'h0}, 1'b0, 64'h0};
    // Odd final k: only the even B bytes carry data.
    dir_tab[13] = '{'{CMD_ACCUM, 3'd0, 3'd4, A_LO_ONE, 64'h00FF_0080_007F_0001, 64'h0},
                    1'b0, 64'h0};
    dir_tab[14] = '{'{CMD_EMIT, 3'd3, 3'd4, A_ZERO, 64'h0, 64'h0},
                    1'b1, 64'hFFFF_FF80_007F_0001};
    dir_tab[15] = '{'{CMD_ACCUM, 3'd2, 3'd5, A_MIXED, 64'h8001_7F80_FF7F_0180, 64'h0},
                    1'b0, 64'h0};
    dir_tab[16] = '{'{CMD_EMIT, 3'd2, 3'd5, A_ZERO, 64'h0, 64'h5A5A_0001_FFFF_8000},
                    1'b0, 64'h0};

    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    for (int i = 0; i < DIR_ROWS; i++) begin
      send_cmd(dir_tab[i].op, dir_tab[i].typed, dir_tab[i].c_typed, 0);
    end

    // Each phase starts from an idle block with new scales.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_emits_drained();
      write_scale(CFG_ALPHA, phase_alpha[ph]);
      write_scale(CFG_BETA, phase_beta[ph]);
      run_random_mix(RANDOM_ITEMS, phase_idle[ph]);
      run_tile_sweep(phase_idle[ph]);
    end

    wait_emits_drained();

    $display("Covered %0d accumulate and %0d checked emit transfers over %0d scale settings,",
             accum_count, emit_count, NUM_PHASES + 1);
    $display("including full tile sweeps, out-of-tile rows and sender gaps of up to 4 cycles.");
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### sim.f
sv/imacc_pkg.sv
sv/int8_tile_matmul_accumulator_unit.sv
tb/sv/tb_int8_tile_matmul_accumulator_unit.sv
